>>> src/obrm_pkg.sv
// ---------------------------------------------------------------------------
// obrm_pkg: shared definitions for the outer bank register mapper
// Types, codes and widths used by the register file, the translator and
// the top level.
// ---------------------------------------------------------------------------
package obrm_pkg;

    localparam int BANK_BITS = 13;
    localparam int NUM_OUTER = 5;
    localparam int CNT_BITS  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PRG   = 2'd1;
    localparam logic [1:0] OP_CHR   = 2'd2;

    localparam logic [1:0] ROMW_NONE = 2'd0;
    localparam logic [1:0] ROMW_RO   = 2'd1;
    localparam logic [1:0] ROMW_RW   = 2'd2;

    localparam logic [2:0] REG_BASE = 3'd0;
    localparam logic [2:0] REG_HIGH = 3'd1;
    localparam logic [2:0] REG_CHR  = 3'd2;
    localparam logic [2:0] REG_LOCK = 3'd3;
    localparam logic [2:0] REG_RAM  = 3'd4;
    localparam logic [2:0] REG_LAST = 3'd4;

    localparam logic [3:0] LAYOUT_ALT   = 4'd2;
    localparam logic [3:0] LAYOUT_NARROW = 4'd4;
    localparam logic [3:0] LAYOUT_DUAL  = 4'd6;
    localparam logic [3:0] LAYOUT_WPROT = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBMAPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd2;

    typedef logic [NUM_OUTER-1:0][7:0] t_outer;

    typedef struct packed {
        logic [3:0]          submapper;
        logic                chr_ram_present;
        logic [CNT_BITS-1:0] prg_bank_count;
    } t_cfg;

    typedef struct packed {
        logic [BANK_BITS-1:0] bank;
        logic                 chr_ram_select;
        logic [1:0]           chr_rom_write;
    } t_xlate;

endpackage

>>> src/obrm_regs.sv
// ---------------------------------------------------------------------------
// obrm_regs: outer register file
// Holds the five outer registers, applies the lock bit and the self-masking
// of register 2, and reports whether a write was stored.
// ---------------------------------------------------------------------------
module obrm_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [2:0]          i_wr_idx,
    input  logic [7:0]          i_wr_data,
    output logic                o_wr_taken,
    output obrm_pkg::t_outer    o_regs
);

    obrm_pkg::t_outer r_regs;
    obrm_pkg::t_outer n_regs;
    logic [7:0]       w_old2;
    logic [7:0]       w_data2;
    logic             w_allowed;

    always_comb begin
        w_old2    = r_regs[obrm_pkg::REG_CHR];
        w_allowed = (i_wr_idx <= obrm_pkg::REG_LAST) &&
                    (!r_regs[obrm_pkg::REG_LOCK][7] || i_wr_idx == obrm_pkg::REG_CHR);
        w_data2   = i_wr_data;
        if (w_old2[7]) begin
            w_data2[7:4] = w_old2[7:4];
        end
        w_data2[3:1] = w_data2[3:1] & ~w_old2[6:4];
        n_regs = r_regs;
        if (i_wr_en && w_allowed) begin
            if (i_wr_idx == obrm_pkg::REG_CHR) begin
                n_regs[i_wr_idx] = w_data2;
            end else begin
                n_regs[i_wr_idx] = i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_wr_taken = w_allowed;
    assign o_regs     = r_regs;

`ifndef SYNTH
    a_lock_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && r_regs[obrm_pkg::REG_LOCK][7] && i_wr_idx != obrm_pkg::REG_CHR)
        |=> $stable(r_regs))
        else $error("locked write changed the outer registers");
    a_reg2_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs[obrm_pkg::REG_CHR][7] |=> r_regs[obrm_pkg::REG_CHR][7])
        else $error("register 2 bit 7 cleared without reset");
`endif

endmodule

>>> src/obrm_xlate.sv
// ---------------------------------------------------------------------------
// obrm_xlate: PRG and CHR bank translation
// Combines the MMC3 bank number with base and mask bits of the outer
// registers for every submapper layout, GNROM mode and CHR RAM selection.
// ---------------------------------------------------------------------------
module obrm_xlate (
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_value,
    input  logic [2:0]        i_window,
    input  logic              i_chr_bit,
    input  obrm_pkg::t_outer  i_regs,
    input  obrm_pkg::t_cfg    i_cfg,
    output obrm_pkg::t_xlate  o_res
);

    logic [7:0]                     r0, r1, r2, r3, r4;
    logic [3:0]                     w_layout;
    logic [obrm_pkg::CNT_BITS-1:0]  w_base;
    logic [obrm_pkg::CNT_BITS-1:0]  w_pmask;
    logic [obrm_pkg::CNT_BITS-1:0]  w_cbase;
    logic [obrm_pkg::CNT_BITS-1:0]  w_cmask;
    logic [obrm_pkg::CNT_BITS-1:0]  w_pv;
    logic [obrm_pkg::CNT_BITS-1:0]  w_cv;
    logic [obrm_pkg::CNT_BITS-1:0]  w_prg;
    logic [obrm_pkg::CNT_BITS-1:0]  w_chr;
    logic                           w_sel;

    always_comb begin
        r0 = i_regs[obrm_pkg::REG_BASE];
        r1 = i_regs[obrm_pkg::REG_HIGH];
        r2 = i_regs[obrm_pkg::REG_CHR];
        r3 = i_regs[obrm_pkg::REG_LOCK];
        r4 = i_regs[obrm_pkg::REG_RAM];
        w_layout = {i_cfg.submapper[3:1], 1'b0};

        w_pmask = {5'd0, r1[5], r1[6], ~r1[7], ~r0[6], 4'hF};
        if (w_layout == obrm_pkg::LAYOUT_ALT) begin
            w_base = {1'b0, r0[5:4], r1[1], r1[2], r1[3], r0[2:0], r3[3:1], 1'b0};
        end else if (w_layout == obrm_pkg::LAYOUT_NARROW) begin
            w_base = {4'd0, r0[5:4], r0[2:0], r3[3:1], 1'b0};
        end else begin
            w_base = {1'b0, r0[5:4], r1[3:2], r1[4], r0[2:0], r3[3:1], 1'b0};
        end
        w_sel = r0[7] ? r0[3] : i_chr_bit;
        if (w_layout == obrm_pkg::LAYOUT_DUAL) begin
            w_base = w_base & (i_cfg.prg_bank_count - 1'b1);
            if (w_sel) begin
                w_base = w_base | i_cfg.prg_bank_count;
            end
        end
        w_pv = {5'd0, i_value};
        if (r3[4]) begin
            if (w_layout == obrm_pkg::LAYOUT_ALT) begin
                w_pmask = r1[4] ? 13'h001 : 13'h003;
            end else begin
                w_pmask = r1[1] ? 13'h003 : 13'h001;
            end
            w_pv = {10'd0, i_window};
        end
        w_prg = (w_base & ~w_pmask) | (w_pv & w_pmask);

        w_cbase = {3'd0, r0[5:3], r2[3:0], 3'd0};
        w_cmask = r0[7] ? 13'h07F : 13'h0FF;
        w_cv    = {5'd0, i_value};
        if (r3[4]) begin
            w_cmask = 13'h007;
            w_cv    = {10'd0, i_window};
        end
        w_chr = (w_cbase & ~w_cmask) | (w_cv & w_cmask);

        o_res = '0;
        case (i_op)
            obrm_pkg::OP_PRG: begin
                o_res.bank = w_prg[obrm_pkg::BANK_BITS-1:0];
            end
            obrm_pkg::OP_CHR: begin
                o_res.bank = w_chr[obrm_pkg::BANK_BITS-1:0];
                o_res.chr_ram_select = i_cfg.chr_ram_present && r4[0] &&
                                       (i_value[7:1] == r4[7:1]);
                if (w_layout == obrm_pkg::LAYOUT_WPROT) begin
                    o_res.chr_rom_write = r0[4] ? obrm_pkg::ROMW_RO : obrm_pkg::ROMW_RW;
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

>>> src/outer_bank_register_mapper_core.sv
// ---------------------------------------------------------------------------
// outer_bank_register_mapper_core: outer bank logic of an MMC3 multicart
// Input register, a combinational translation or register write, and an
// output register that holds the result word until it is taken.
// ---------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   tuser = op; tdata = reg_index, value, window, mmc3_chr_bit
//  m_axis    out  tdata = bank, chr_ram_select, chr_rom_write, write_taken
//  cfg       in   i_cfg_we, i_cfg_index, i_cfg_data, no read-back
//
// One word per cycle is accepted and one result leaves per cycle while
// the receiver takes results; a word passes the input register and then
// the result register. A stalled result holds in the output register while
// the input register still takes one more word. Reset is synchronous and
// clears the outer registers and the configuration to their defaults.
// ---------------------------------------------------------------------------
module outer_bank_register_mapper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] reg_index, [10:3] value, [13:11] window, [14] mmc3_chr_bit
    input  logic [15:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] bank, [13] chr_ram_select, [15:14] chr_rom_write, [16] write_taken
    output logic [23:0] m_axis_tdata
);

    obrm_pkg::t_cfg   r_cfg;
    obrm_pkg::t_outer w_regs;
    obrm_pkg::t_xlate w_res;
    logic             r_in_valid;
    logic [15:0]      r_in_data;
    logic [1:0]       r_in_op;
    logic             r_out_valid;
    logic [23:0]      r_out_data;
    logic             w_advance;
    logic             w_wr_en;
    logic             w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.submapper       <= 4'd0;
            r_cfg.chr_ram_present <= 1'b0;
            r_cfg.prg_bank_count  <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                obrm_pkg::CFG_SUBMAPPER: r_cfg.submapper       <= i_cfg_data[3:0];
                obrm_pkg::CFG_CHR_RAM:   r_cfg.chr_ram_present <= i_cfg_data[0];
                obrm_pkg::CFG_PRG_COUNT: r_cfg.prg_bank_count  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_wr_en       = w_advance && (r_in_op == obrm_pkg::OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    obrm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (r_in_data[2:0]),
        .i_wr_data  (r_in_data[10:3]),
        .o_wr_taken (w_taken),
        .o_regs     (w_regs)
    );

    obrm_xlate u_xlate (
        .i_op      (r_in_op),
        .i_value   (r_in_data[10:3]),
        .i_window  (r_in_data[13:11]),
        .i_chr_bit (r_in_data[14]),
        .i_regs    (w_regs),
        .i_cfg     (r_cfg),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {7'd0, (r_in_op == obrm_pkg::OP_WRITE) && w_taken,
                           w_res.chr_rom_write, w_res.chr_ram_select, w_res.bank};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_write_no_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("write result carries bank data");
    a_romw_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:14] != 2'd3))
        else $error("undefined CHR ROM protection code");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");
`endif

endmodule

>>> dv/outer_bank_register_mapper_core_test.sv
// ---------------------------------------------------------------------------
// outer_bank_register_mapper_core_test: self-checking bench for the mapper
// A directed table walks the field extremes, every operation and the write
// rules. Random phases follow, one per board configuration, with bursty
// input and a stalling receiver. Each result word is compared field by field
// with its pinned table value or the bench's model of the outer registers
// and the bank translation. The lock bit and the register 2 self-mask
// cannot be undone without reset, so they are set only in the last phase.
// ---------------------------------------------------------------------------
module outer_bank_register_mapper_core_test;

    localparam int BANK_BITS  = obrm_pkg::BANK_BITS;
    localparam int NUM_OUTER  = obrm_pkg::NUM_OUTER;
    localparam int CFG_IDX_W  = obrm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = obrm_pkg::CFG_DATA_W;

    localparam logic [1:0] OP_WRITE  = obrm_pkg::OP_WRITE;
    localparam logic [1:0] OP_PRG    = obrm_pkg::OP_PRG;
    localparam logic [1:0] OP_CHR    = obrm_pkg::OP_CHR;
    localparam logic [1:0] ROMW_NONE = obrm_pkg::ROMW_NONE;
    localparam logic [1:0] ROMW_RO   = obrm_pkg::ROMW_RO;
    localparam logic [1:0] ROMW_RW   = obrm_pkg::ROMW_RW;

    localparam logic [2:0] REG_BASE = obrm_pkg::REG_BASE;
    localparam logic [2:0] REG_HIGH = obrm_pkg::REG_HIGH;
    localparam logic [2:0] REG_CHR  = obrm_pkg::REG_CHR;
    localparam logic [2:0] REG_LOCK = obrm_pkg::REG_LOCK;
    localparam logic [2:0] REG_RAM  = obrm_pkg::REG_RAM;
    localparam logic [2:0] REG_LAST = obrm_pkg::REG_LAST;

    localparam logic [3:0] LAYOUT_ALT    = obrm_pkg::LAYOUT_ALT;
    localparam logic [3:0] LAYOUT_NARROW = obrm_pkg::LAYOUT_NARROW;
    localparam logic [3:0] LAYOUT_DUAL   = obrm_pkg::LAYOUT_DUAL;
    localparam logic [3:0] LAYOUT_WPROT  = obrm_pkg::LAYOUT_WPROT;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBMAPPER = obrm_pkg::CFG_SUBMAPPER;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = obrm_pkg::CFG_CHR_RAM;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = obrm_pkg::CFG_PRG_COUNT;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int LOCK_ROW     = 24;
    localparam int ROWS         = 33;
    localparam int PHASES       = 16;
    localparam int PHASE_WORDS  = 95;
    localparam int FINAL_WORDS  = 100;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 80;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_index;
        logic [7:0] value;
        logic [2:0] window;
        logic       mmc3_chr_bit;
    } t_word_in;

    typedef struct packed {
        logic [BANK_BITS-1:0] bank;
        logic                 chr_ram_select;
        logic [1:0]           chr_rom_write;
        logic                 write_taken;
    } t_word_out;

    typedef struct packed {
        t_word_in  stim;
        logic      pinned;
        t_word_out pinned_out;
    } t_row;

    typedef struct packed {
        logic [3:0]  submapper;
        logic        chr_ram;
        logic [12:0] count;
    } t_board;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;

    logic [7:0]  outer_q [NUM_OUTER];
    logic [3:0]  board_sub   = 4'd0;
    logic        board_ram   = 1'b0;
    logic [12:0] board_count = 13'd4096;

    t_word_out   pending_xlate [$];
    int unsigned fail_count     = 0;
    int unsigned results_seen   = 0;
    int unsigned burst_left     = 0;
    logic        long_hold_done = 1'b0;

    t_row directed_rows [ROWS] = '{
        '{'{OP_PRG,   3'd0,         8'hFF, 3'd7, 1'b0}, 1'b1, '{13'h03F, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_CHR,   3'd0,         8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h0FF, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_PRG,   3'd0,         8'h00, 3'd0, 1'b1}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_CHR,   3'd0,         8'h00, 3'd7, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_NONE,  3'd7,         8'hFF, 3'd7, 1'b1}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_WRITE, REG_SPARE_LO, 8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_WRITE, REG_SPARE_HI, 8'h00, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_WRITE, REG_BASE,     8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_PRG,   3'd0,         8'hA5, 3'd4, 1'b0}, 1'b0, '0},
        '{'{OP_CHR,   3'd0,         8'h5A, 3'd3, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_HIGH,     8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_PRG,   3'd0,         8'hFF, 3'd5, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE, REG_CHR,      8'h70, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_WRITE, REG_CHR,      8'h0E, 3'd0, 1'b0}, 1'b0, '0},
        '{'{OP_CHR,   3'd0,         8'hFF, 3'd7, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_RAM,      8'h03, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_CHR,   3'd0,         8'h03, 3'd0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_LOCK,     8'h1E, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_PRG,   3'd0,         8'h00, 3'd6, 1'b0}, 1'b0, '0},
        '{'{OP_CHR,   3'd0,         8'h00, 3'd5, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE, REG_HIGH,     8'h02, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_PRG,   3'd0,         8'hFF, 3'd7, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE, REG_BASE,     8'h00, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_WRITE, REG_LOCK,     8'h00, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_WRITE, REG_CHR,      8'h80, 3'd0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_CHR,      8'h7F, 3'd0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_LOCK,     8'h80, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b1}},
        '{'{OP_WRITE, REG_BASE,     8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_WRITE, REG_LOCK,     8'h00, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_WRITE, REG_CHR,      8'h0F, 3'd0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE, REG_RAM,      8'hFF, 3'd0, 1'b0}, 1'b1, '{13'h000, 1'b0, ROMW_NONE, 1'b0}},
        '{'{OP_PRG,   3'd0,         8'hFF, 3'd7, 1'b1}, 1'b0, '0},
        '{'{OP_CHR,   3'd0,         8'hFF, 3'd7, 1'b1}, 1'b0, '0}
    };

    t_board board_plan [PHASES] = '{
        '{4'd0,  1'b0, 13'd4096}, '{4'd1,  1'b1, 13'd4096}, '{4'd2,  1'b0, 13'd512},
        '{4'd3,  1'b1, 13'd256},  '{4'd4,  1'b1, 13'd1024}, '{4'd5,  1'b0, 13'd4096},
        '{4'd6,  1'b1, 13'd1},    '{4'd6,  1'b0, 13'd4096}, '{4'd7,  1'b1, 13'd3},
        '{4'd6,  1'b1, 13'd0},    '{4'd7,  1'b0, 13'd8191}, '{4'd8,  1'b1, 13'd128},
        '{4'd9,  1'b0, 13'd2048}, '{4'd10, 1'b1, 13'd64},   '{4'd15, 1'b1, 13'd4096},
        '{4'd6,  1'b0, 13'd32}
    };

    localparam t_board LOCK_BOARD = '{4'd8, 1'b1, 13'd2};

    outer_bank_register_mapper_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [31:0] prg_bank_of(input logic [7:0] v8, input logic [2:0] win,
                                                input logic chrbit);
        logic [31:0] r0, r1, r3, layout, base, mask, v, cnt;
        logic        sel;
        r0     = 32'(outer_q[REG_BASE]);
        r1     = 32'(outer_q[REG_HIGH]);
        r3     = 32'(outer_q[REG_LOCK]);
        layout = 32'(board_sub & 4'hE);
        v      = 32'(v8);
        cnt    = 32'(board_count);
        mask   = 32'h0F | ((~r0 >> 2) & 32'h10) | ((~r1 >> 2) & 32'h20)
               | (r1 & 32'h40) | ((r1 << 2) & 32'h80);
        if (layout == 32'(LAYOUT_ALT)) begin
            base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r1 << 4) & 32'h80)
                 | ((r1 << 6) & 32'h100) | ((r1 << 8) & 32'h200) | ((r0 << 6) & 32'hC00);
        end else if (layout == 32'(LAYOUT_NARROW)) begin
            base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r0 << 3) & 32'h180);
        end else begin
            base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r1 << 3) & 32'h80)
                 | ((r1 << 6) & 32'h300) | ((r0 << 6) & 32'hC00);
            if (layout == 32'(LAYOUT_DUAL)) begin
                sel  = r0[7] ? r0[3] : chrbit;
                base = base & (cnt - 32'd1);
                if (sel) begin
                    base = base | cnt;
                end
            end
        end
        if (r3[4]) begin
            if (layout == 32'(LAYOUT_ALT)) begin
                mask = r1[4] ? 32'h01 : 32'h03;
            end else begin
                mask = r1[1] ? 32'h03 : 32'h01;
            end
            v = 32'(win);
        end
        return (base & ~mask) | (v & mask);
    endfunction

    function automatic logic [31:0] chr_bank_of(input logic [7:0] v8, input logic [2:0] win);
        logic [31:0] r0, r2, base, mask, v;
        r0   = 32'(outer_q[REG_BASE]);
        r2   = 32'(outer_q[REG_CHR]);
        v    = 32'(v8);
        base = ((r0 << 4) & 32'h380) | ((r2 << 3) & 32'h078);
        mask = r0[7] ? 32'h7F : 32'hFF;
        if (outer_q[REG_LOCK][4]) begin
            mask = 32'h07;
            v    = 32'(win);
        end
        return (base & ~mask) | (v & mask);
    endfunction

    function automatic t_word_out map_word(input t_word_in w);
        t_word_out   r;
        logic [7:0]  v, old;
        logic [31:0] b;
        r = '0;
        case (w.op)
            OP_WRITE: begin
                if (w.reg_index <= REG_LAST
                    && (!outer_q[REG_LOCK][7] || w.reg_index == REG_CHR)) begin
                    v = w.value;
                    if (w.reg_index == REG_CHR) begin
                        old = outer_q[REG_CHR];
                        if (old[7]) begin
                            v = {old[7:4], v[3:0]};
                        end
                        v = v & ({4'b0, ~old[6:4], 1'b0} | 8'hF1);
                    end
                    outer_q[w.reg_index] = v;
                    r.write_taken = 1'b1;
                end
            end
            OP_PRG: begin
                b      = prg_bank_of(w.value, w.window, w.mmc3_chr_bit);
                r.bank = b[BANK_BITS-1:0];
            end
            OP_CHR: begin
                r.chr_ram_select = board_ram && outer_q[REG_RAM][0]
                                   && (w.value[7:1] == outer_q[REG_RAM][7:1]);
                if ((board_sub & 4'hE) == LAYOUT_WPROT) begin
                    r.chr_rom_write = outer_q[REG_BASE][4] ? ROMW_RO : ROMW_RW;
                end else begin
                    r.chr_rom_write = ROMW_NONE;
                end
                b      = chr_bank_of(w.value, w.window);
                r.bank = b[BANK_BITS-1:0];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Before the last phase the lock bit and the register 2 self-mask stay clear.
    function automatic t_word_in random_word(input logic free_writes);
        t_word_in    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            w.op = OP_NONE;
        end else if (pick < 35) begin
            w.op = OP_WRITE;
        end else if (pick < 68) begin
            w.op = OP_PRG;
        end else begin
            w.op = OP_CHR;
        end
        w.reg_index    = 3'($urandom_range(0, 7));
        w.value        = 8'($urandom);
        w.window       = 3'($urandom_range(0, 7));
        w.mmc3_chr_bit = 1'($urandom_range(0, 1));
        if (w.op == OP_WRITE && $urandom_range(0, 4) != 0) begin
            w.reg_index = 3'($urandom_range(0, REG_LAST));
        end
        if (w.op == OP_CHR && $urandom_range(0, 3) == 0) begin
            w.value = {outer_q[REG_RAM][7:1], w.value[0]};
        end
        if (!free_writes && w.op == OP_WRITE
            && (w.reg_index == REG_LOCK || w.reg_index == REG_CHR)) begin
            w.value[7] = 1'b0;
        end
        return w;
    endfunction

    task automatic offer_word(input t_word_in w, input logic pinned, input t_word_out pinned_out);
        t_word_out predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.mmc3_chr_bit, w.window, w.value, w.reg_index};
        s_axis_tuser  <= w.op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = map_word(w);
        pending_xlate.push_back(pinned ? pinned_out : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (pending_xlate.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_board(input t_board b);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SUBMAPPER;
        i_cfg_data  <= CFG_DATA_W'(b.submapper);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHR_RAM;
        i_cfg_data  <= CFG_DATA_W'(b.chr_ram);
        @(posedge i_clk);
        i_cfg_index <= CFG_PRG_COUNT;
        i_cfg_data  <= b.count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board_sub   = b.submapper;
        board_ram   = b.chr_ram;
        board_count = b.count;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("outer_bank_register_mapper_core: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        t_word_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[12:0], m_axis_tdata[13], m_axis_tdata[15:14],
                   m_axis_tdata[16]};
            results_seen++;
            if (pending_xlate.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_xlate.pop_front();
                if (got.bank !== want.bank) begin
                    $display("%0t: bank expected %h got %h", $time, want.bank, got.bank);
                    fail_count++;
                end
                if (got.chr_ram_select !== want.chr_ram_select) begin
                    $display("%0t: chr_ram_select expected %b got %b", $time,
                             want.chr_ram_select, got.chr_ram_select);
                    fail_count++;
                end
                if (got.chr_rom_write !== want.chr_rom_write) begin
                    $display("%0t: chr_rom_write expected %0d got %0d", $time,
                             want.chr_rom_write, got.chr_rom_write);
                    fail_count++;
                end
                if (got.write_taken !== want.write_taken) begin
                    $display("%0t: write_taken expected %b got %b", $time,
                             want.write_taken, got.write_taken);
                    fail_count++;
                end
            end
        end
    end

    // The receiver stalls according to a mode that changes at random, and
    // once holds off long enough for the input side to back up.
    initial begin
        int unsigned mode, mode_left, tick;
        logic        ready;
        mode_left = 0;
        tick      = 0;
        mode      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (!long_hold_done && results_seen >= 500 && s_axis_tvalid) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       ready = 1'b1;
                    1:       ready = 1'($urandom_range(0, 1));
                    2:       ready = ($urandom_range(0, 3) != 0);
                    default: ready = ((tick % 7) > 2);
                endcase
                m_axis_tready <= ready;
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_OUTER; i++) begin
            outer_q[i] = 8'h00;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < LOCK_ROW; r++) begin
            offer_word(directed_rows[r].stim, directed_rows[r].pinned,
                       directed_rows[r].pinned_out);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            load_board(board_plan[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                offer_word(random_word(1'b0), 1'b0, '0);
            end
            drain_results();
        end

        load_board(LOCK_BOARD);
        for (int r = LOCK_ROW; r < ROWS; r++) begin
            offer_word(directed_rows[r].stim, directed_rows[r].pinned,
                       directed_rows[r].pinned_out);
        end
        for (int n = 0; n < FINAL_WORDS; n++) begin
            offer_word(random_word(1'b1), 1'b0, '0);
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("outer_bank_register_mapper_core: match");
        end else begin
            $display("outer_bank_register_mapper_core: mismatch");
        end
        $finish;
    end

endmodule
